// ----- rtl/core/gd_pkg.sv -----
// ----------------------------------------------------------------------------
// gd_pkg
// Shared types and constants of the two-button gesture detector.
// ----------------------------------------------------------------------------
package gd_pkg;

  // field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [IDX_W-1:0] REG_BOTH_WINDOW = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd30;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd500;
  localparam logic [CFG_W-1:0] BOTH_WINDOW_RST = 16'd50;

  // event source codes
  localparam logic [1:0] ID_LEFT  = 2'd0;
  localparam logic [1:0] ID_RIGHT = 2'd1;
  localparam logic [1:0] ID_BOTH  = 2'd2;

  // event kind codes
  localparam logic [1:0] KIND_SHORT  = 2'd0;
  localparam logic [1:0] KIND_LSTART = 2'd1;
  localparam logic [1:0] KIND_LSTOP  = 2'd2;

  // configuration register set
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] both_window_ms;
  } gd_cfg_t;

  // one poll as held in the input register
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              left_pressed;
    logic              right_pressed;
  } gd_poll_t;

  // control from the top level to each button tracker
  typedef struct packed {
    logic step;       // a poll is processed this cycle
    logic disarm;     // both gesture starts, drop individual timing
    logic indiv_en;   // individual press handling allowed
    logic pair_prev;  // both levels were pressed on the previous poll
  } gd_btn_ctl_t;

  // event candidate from one button tracker
  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [TIME_W-1:0] held;
  } gd_btn_evt_t;

endpackage

// ----- rtl/core/gd_poll_if.sv -----
// ----------------------------------------------------------------------------
// gd_poll_if
// Poll channel: valid/ready handshake with time and raw button levels.
// ----------------------------------------------------------------------------
interface gd_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        left_pressed;
  logic        right_pressed;

  modport source (output valid, output now_ms, output left_pressed,
                  output right_pressed, input ready);
  modport sink   (input valid, input now_ms, input left_pressed,
                  input right_pressed, output ready);
endinterface

// ----- rtl/core/gd_event_if.sv -----
// ----------------------------------------------------------------------------
// gd_event_if
// Event channel: valid/ready handshake with one gesture event.
// ----------------------------------------------------------------------------
interface gd_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  button_id;
  logic [1:0]  event_kind;
  logic [31:0] stamp_ms;
  logic [31:0] held_ms;
  logic        last_of_poll;

  modport source (output valid, output button_id, output event_kind,
                  output stamp_ms, output held_ms, output last_of_poll,
                  input ready);
  modport sink   (input valid, input button_id, input event_kind,
                  input stamp_ms, input held_ms, input last_of_poll,
                  output ready);
endinterface

// ----- rtl/core/gd_button.sv -----
// ----------------------------------------------------------------------------
// gd_button
// Debounce and individual press tracking for one button.
// ----------------------------------------------------------------------------
module gd_button
  import gd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  gd_btn_ctl_t       ctl,
  input  logic [TIME_W-1:0] now,
  input  logic              raw,
  input  gd_cfg_t           cfg,
  output logic              cur,
  output logic              prv,
  output gd_btn_evt_t       evt
);

  logic              level, level_next;
  logic [TIME_W-1:0] last_change, last_change_next;
  logic              prev, prev_next;
  logic [TIME_W-1:0] start, start_next;
  logic              long_sent, long_sent_next;

  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] hold;
  logic              change;
  logic              armed;

  // debounce: accept a level change only after the lockout
  assign since_change = now - last_change;
  assign change = (raw != level) &&
                  (since_change >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});
  assign cur = change ? raw : level;
  assign prv = prev;

  assign hold  = now - start;
  assign armed = (start != '0);

  // press tracking and event candidate
  always_comb begin
    level_next       = level;
    last_change_next = last_change;
    prev_next        = prev;
    start_next       = start;
    long_sent_next   = long_sent;
    evt              = '0;
    if (ctl.step) begin
      if (change) begin
        level_next       = raw;
        last_change_next = now;
      end
      prev_next = cur;
      if (ctl.disarm) begin
        start_next = '0;
      end else if (ctl.indiv_en) begin
        if (cur && !prev && !ctl.pair_prev) begin
          start_next     = now;
          long_sent_next = 1'b0;
        end else if (cur && prev && armed) begin
          if (!long_sent &&
              (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms})) begin
            long_sent_next = 1'b1;
            evt.valid      = 1'b1;
            evt.kind       = KIND_LSTART;
            evt.held       = {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};
          end
        end else if (!cur && prev && armed) begin
          if (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.both_window_ms}) begin
            evt.valid = 1'b1;
            evt.kind  = long_sent ? KIND_LSTOP : KIND_SHORT;
            evt.held  = hold;
          end
          start_next     = '0;
          long_sent_next = 1'b0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= 1'b0;
      last_change <= '0;
      prev        <= 1'b0;
      start       <= '0;
      long_sent   <= 1'b0;
    end else begin
      level       <= level_next;
      last_change <= last_change_next;
      prev        <= prev_next;
      start       <= start_next;
      long_sent   <= long_sent_next;
    end
  end

endmodule

// ----- rtl/core/two_button_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// two_button_gesture_detector
// Debounced left/right/both button gestures with short and long press events.
// ----------------------------------------------------------------------------
// Flow: a transferred poll waits in the input register until the event
//   buffer is free, then is processed and its events offered from the buffer.
// Throughput: one poll per cycle while each poll yields at most one event
//   and evt.ready is high; the buffer drains one event per ready cycle.
// Reset: both buttons released, nothing armed, registers at 30/500/50 ms.
module two_button_gesture_detector
  import gd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  gd_poll_if.sink           poll,
  gd_event_if.source        evt,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int unsigned NSLOT = 3;  // both, left, right

  gd_cfg_t           cfg;
  logic              in_valid;
  gd_poll_t          in_q;
  logic              process;
  logic              buf_free;

  logic              both_active, both_active_next;
  logic [TIME_W-1:0] both_start, both_start_next;
  logic              both_long_sent, both_long_sent_next;

  logic [NSLOT-1:0]  mask, mask_next, new_mask;
  logic [NSLOT-1:0]  head;
  logic [TIME_W-1:0] stamp;
  logic [1:0]        slot_kind [NSLOT];
  logic [TIME_W-1:0] slot_held [NSLOT];
  logic [1:0]        both_kind;
  logic [TIME_W-1:0] both_held;
  logic              both_evt;

  gd_btn_ctl_t       ctl;
  logic              cur_l, cur_r, prv_l, prv_r;
  logic              both_now;
  logic [TIME_W-1:0] both_dur;
  gd_btn_evt_t       evt_l, evt_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms    <= DEBOUNCE_RST;
      cfg.long_press_ms  <= LONG_PRESS_RST;
      cfg.both_window_ms <= BOTH_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DEBOUNCE:    cfg.debounce_ms    <= cfg_wdata;
        REG_LONG_PRESS:  cfg.long_press_ms  <= cfg_wdata;
        REG_BOTH_WINDOW: cfg.both_window_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  assign buf_free   = (mask == '0) || (evt.ready && (mask == head));
  assign process    = in_valid && buf_free;
  assign poll.ready = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.ready && poll.valid) begin
      in_q.now_ms        <= poll.now_ms;
      in_q.left_pressed  <= poll.left_pressed;
      in_q.right_pressed <= poll.right_pressed;
    end
  end

  // per-button trackers
  gd_button u_left (
    .clk (clk), .rst (rst), .ctl (ctl), .now (in_q.now_ms),
    .raw (in_q.left_pressed), .cfg (cfg),
    .cur (cur_l), .prv (prv_l), .evt (evt_l)
  );

  gd_button u_right (
    .clk (clk), .rst (rst), .ctl (ctl), .now (in_q.now_ms),
    .raw (in_q.right_pressed), .cfg (cfg),
    .cur (cur_r), .prv (prv_r), .evt (evt_r)
  );

  // both-button gesture
  assign both_now = cur_l && cur_r;
  assign both_dur = in_q.now_ms - both_start;

  always_comb begin
    both_active_next    = both_active;
    both_start_next     = both_start;
    both_long_sent_next = both_long_sent;
    both_evt            = 1'b0;
    both_kind           = KIND_SHORT;
    both_held           = both_dur;
    if (process) begin
      if (both_now && !both_active) begin
        both_active_next    = 1'b1;
        both_start_next     = in_q.now_ms;
        both_long_sent_next = 1'b0;
      end else if (both_active && both_now && !both_long_sent) begin
        if (both_dur >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms}) begin
          both_long_sent_next = 1'b1;
          both_evt            = 1'b1;
          both_kind           = KIND_LSTART;
          both_held           = {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms};
        end
      end else if (both_active && !both_now) begin
        both_evt         = 1'b1;
        both_kind        = both_long_sent ? KIND_LSTOP : KIND_SHORT;
        both_active_next = 1'b0;
      end
    end
  end

  always_comb begin
    ctl.step      = process;
    ctl.disarm    = both_now && !both_active;
    ctl.indiv_en  = !both_active_next && !both_now;
    ctl.pair_prev = prv_l && prv_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      both_active    <= 1'b0;
      both_start     <= '0;
      both_long_sent <= 1'b0;
    end else begin
      both_active    <= both_active_next;
      both_start     <= both_start_next;
      both_long_sent <= both_long_sent_next;
    end
  end

  // event buffer: one slot per source, drained in order both, left, right
  assign new_mask = {evt_r.valid, evt_l.valid, both_evt};
  assign head     = mask & (~mask + {{(NSLOT-1){1'b0}}, 1'b1});

  always_comb begin
    mask_next = mask;
    if (process) begin
      mask_next = new_mask;
    end else if (evt.valid && evt.ready) begin
      mask_next = mask & ~head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      stamp        <= in_q.now_ms;
      slot_kind[0] <= both_kind;
      slot_held[0] <= both_held;
      slot_kind[1] <= evt_l.kind;
      slot_held[1] <= evt_l.held;
      slot_kind[2] <= evt_r.kind;
      slot_held[2] <= evt_r.held;
    end
  end

  // output selection from the buffer head
  assign evt.valid        = (mask != '0);
  assign evt.last_of_poll = (mask == head);
  assign evt.stamp_ms     = stamp;

  always_comb begin
    unique case (head)
      3'b001: begin
        evt.button_id  = ID_BOTH;
        evt.event_kind = slot_kind[0];
        evt.held_ms    = slot_held[0];
      end
      3'b010: begin
        evt.button_id  = ID_LEFT;
        evt.event_kind = slot_kind[1];
        evt.held_ms    = slot_held[1];
      end
      3'b100: begin
        evt.button_id  = ID_RIGHT;
        evt.event_kind = slot_kind[2];
        evt.held_ms    = slot_held[2];
      end
      default: begin
        evt.button_id  = ID_LEFT;
        evt.event_kind = KIND_SHORT;
        evt.held_ms    = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/gd_checker.sv -----
// ----------------------------------------------------------------------------
// gd_checker
// Port-level checks of the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module gd_checker
  import gd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              poll_ready,
  input logic              evt_valid,
  input logic              evt_ready,
  input logic [1:0]        evt_button_id,
  input logic [1:0]        evt_event_kind,
  input logic [TIME_W-1:0] evt_stamp_ms,
  input logic [TIME_W-1:0] evt_held_ms
);

  // nothing is offered and polls are taken right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!evt_valid && poll_ready))
    else $error("event offered or poll blocked after reset");

  // source and kind codes stay in range
  a_codes: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> ((evt_button_id != 2'd3) && (evt_event_kind != 2'd3)))
    else $error("event carries an undefined code");

  // long-press start reports the 16-bit threshold
  a_lstart_held: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && (evt_event_kind == KIND_LSTART)) |->
      (evt_held_ms[TIME_W-1:CFG_W] == '0))
    else $error("long-press start held time exceeds threshold width");

  // a stalled event holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_ready) |=>
      (evt_valid && $stable(evt_button_id) && $stable(evt_event_kind) &&
       $stable(evt_stamp_ms) && $stable(evt_held_ms)))
    else $error("stalled event changed");

endmodule

bind two_button_gesture_detector gd_checker u_gd_checker (
  .clk            (clk),
  .rst            (rst),
  .poll_ready     (poll.ready),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .evt_button_id  (evt.button_id),
  .evt_event_kind (evt.event_kind),
  .evt_stamp_ms   (evt.stamp_ms),
  .evt_held_ms    (evt.held_ms)
);
